// File: hw/rtl/tmrk4_pkg.sv
// Shared types, coefficients and fixed-point helpers for the roll-axis RK4 stepper.
package tmrk4_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_WB
   } state_type;

   typedef enum logic [3:0] {
      MO_IU,
      MO_II,
      MO_IW,
      MO_WI,
      MO_WW,
      MO_WSQ,
      MO_QR,
      MO_QR2,
      MO_QL,
      MO_QL2,
      MO_HS,
      MO_HB,
      MO_DIV
   } mop_type;

   typedef enum logic [1:0] {
      KIND_CURRENT,
      KIND_SPEED,
      KIND_RATE,
      KIND_ANGLE
   } kind_type;

   typedef enum logic [1:0] {
      REG_VOLT_RIGHT,
      REG_VOLT_LEFT,
      REG_STEP_SIZE,
      REG_STEP_LIMIT
   } reg_type;

   localparam logic signed [31:0] C_IU   = 32'sd1416994595;
   localparam logic signed [31:0] C_II   = 32'sd1360314811;
   localparam logic signed [31:0] C_IW   = 32'sd1197077034;
   localparam logic signed [31:0] C_WI   = 32'sd1708790519;
   localparam logic signed [31:0] C_WW   = 32'sd2036132644;
   localparam logic signed [31:0] C_Q    = 32'sd1847179535;
   localparam logic signed [31:0] C_DIV6 = 32'sd715827883;

   localparam logic [5:0] SH_IU   = 6'd19;
   localparam logic [5:0] SH_II   = 6'd22;
   localparam logic [5:0] SH_IW   = 6'd27;
   localparam logic [5:0] SH_WI   = 6'd22;
   localparam logic [5:0] SH_WW   = 6'd39;
   localparam logic [5:0] SH_Q    = 6'd45;
   localparam logic [5:0] SH_STEP = 6'd32;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Divide by 2^sh truncating toward zero, then saturate.
   function automatic logic signed [31:0] post(input logic signed [63:0] p,
                                               input logic [5:0] sh);
      logic signed [63:0] bias;
      logic signed [63:0] q;
      bias = p[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      q = (p + bias) >>> sh;
      return sat32(q);
   endfunction

   function automatic mop_type mop_of(input kind_type kind, input logic [2:0] op);
      mop_type m;
      m = MO_HB;
      case (kind)
         KIND_CURRENT: begin
            case (op)
               3'd0: m = MO_IU;
               3'd1: m = MO_II;
               3'd2: m = MO_IW;
               3'd3: m = MO_HS;
               default: m = MO_DIV;
            endcase
         end
         KIND_SPEED: begin
            case (op)
               3'd0: m = MO_WI;
               3'd1: m = MO_WW;
               3'd2: m = MO_WSQ;
               3'd3: m = MO_HS;
               default: m = MO_DIV;
            endcase
         end
         KIND_RATE: begin
            case (op)
               3'd0: m = MO_QR;
               3'd1: m = MO_QR2;
               3'd2: m = MO_QL;
               3'd3: m = MO_QL2;
               default: m = MO_HB;
            endcase
         end
         default: m = MO_HB;
      endcase
      return m;
   endfunction

endpackage

// File: hw/rtl/twin_motor_roll_rk4_step.sv
// Top level of the two-motor roll-axis model advanced by at most one RK4 step per item.
//
// The req channel carries one item per tick while req_tready is high; tdata bit 0
// is restart. A restart item clears the six state variables and the step count;
// any other item advances the model one step unless the count reached step_limit.
// The rsp channel returns one item per req item with the state after it.
// A step item is computed on one shared 32 x 32 multiplier, which evaluates every
// product of the four RK4 stages of each current and speed, then the rate and angle
// updates, 74 products in all, each passing through an issue state (ST_MUL) and a
// writeback state (ST_WB).
// Restart items and items past the step limit answer in the cycle after acceptance.
// req_tready is low while a step is computed and while a result waits on rsp;
// a stalled receiver holds the result register and so blocks new items.
// Reset clears the state, the step count and the result valid flag, and loads
// the register defaults: 7.5 V and 7.4 V, a step of 1e-4 s and a limit of 5000.
// The csr port is APB style with pready tied high; registers sit at 4*index.
// The user writes configuration only while the block is idle; nothing enforces it.
module twin_motor_roll_rk4_step #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] current_right, [63:32] current_left, [95:64] speed_right,
   // [127:96] speed_left, [159:128] roll_rate, [191:160] roll_angle,
   // [207:192] elapsed_steps, [208] finished
   output logic [215:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [30:0] VR_RST = 31'(15 << (FRAC_BITS - 1));
   localparam logic [30:0] VL_RST = 31'(((74 << FRAC_BITS) + 5) / 10);
   localparam logic [5:0]  SH_F   = 6'(FRAC_BITS);

   tmrk4_pkg::state_type state_ff, state_in;
   logic [2:0]  v_ff, v_in;
   logic [1:0]  stage_ff, stage_in;
   logic [2:0]  op_ff, op_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [5:0]  sh_ff, sh_in;
   logic signed [33:0] dsum_ff, dsum_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] xs_ff, xs_in;
   logic signed [31:0] ksum_ff, ksum_in;
   logic signed [31:0] nx_ff [6];
   logic signed [31:0] nx_in [6];
   logic signed [31:0] icr_ff, icr_in, icl_ff, icl_in, wr_ff, wr_in, wl_ff, wl_in;
   logic signed [31:0] q_ff, q_in, th_ff, th_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [30:0] vr_ff, vr_in, vl_ff, vl_in;
   logic [23:0] hstep_ff, hstep_in;
   logic [15:0] lim_ff, lim_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [215:0] rsp_data_ff, rsp_data_in;

   tmrk4_pkg::kind_type kind;
   tmrk4_pkg::mop_type  mo;
   logic signed [31:0] x0, h0, h1, xin, dsat, ma, mb, r, k, khalf, qv;
   logic signed [31:0] kabs;
   logic        cfg_wr, req_acc, done, emit;
   logic        fin;
   tmrk4_pkg::reg_type csr_idx;

   assign csr_idx = tmrk4_pkg::reg_type'(csr_paddr[3:2]);
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == tmrk4_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (csr_idx)
         tmrk4_pkg::REG_VOLT_RIGHT: csr_prdata = {1'b0, vr_ff};
         tmrk4_pkg::REG_VOLT_LEFT:  csr_prdata = {1'b0, vl_ff};
         tmrk4_pkg::REG_STEP_SIZE:  csr_prdata = {8'd0, hstep_ff};
         default:                   csr_prdata = {16'd0, lim_ff};
      endcase
   end

   always_comb begin
      case (v_ff)
         3'd0: begin
            x0 = icr_ff; h0 = wr_ff; h1 = $signed({1'b0, vr_ff});
            kind = tmrk4_pkg::KIND_CURRENT;
         end
         3'd1: begin
            x0 = icl_ff; h0 = wl_ff; h1 = $signed({1'b0, vl_ff});
            kind = tmrk4_pkg::KIND_CURRENT;
         end
         3'd2: begin
            x0 = wr_ff; h0 = icr_ff; h1 = 32'sd0; kind = tmrk4_pkg::KIND_SPEED;
         end
         3'd3: begin
            x0 = wl_ff; h0 = icl_ff; h1 = 32'sd0; kind = tmrk4_pkg::KIND_SPEED;
         end
         3'd4: begin
            x0 = q_ff; h0 = wr_ff; h1 = wl_ff; kind = tmrk4_pkg::KIND_RATE;
         end
         default: begin
            x0 = th_ff; h0 = q_ff; h1 = 32'sd0; kind = tmrk4_pkg::KIND_ANGLE;
         end
      endcase
   end

   assign mo   = tmrk4_pkg::mop_of(kind, op_ff);
   assign xin  = (stage_ff == 2'd0) ? x0 : xs_ff;
   assign dsat = tmrk4_pkg::sat32(64'(dsum_ff));
   assign kabs = ksum_ff[31] ? -ksum_ff : ksum_ff;
   assign r    = tmrk4_pkg::post(prod_ff, sh_ff);
   assign k    = r;
   assign khalf = (k + $signed({31'd0, k[31]})) >>> 1;
   assign qv   = ksum_ff[31] ? -r : r;

   always_comb begin
      ma = dsat;
      mb = $signed({8'd0, hstep_ff});
      sh_in = tmrk4_pkg::SH_STEP;
      case (mo)
         tmrk4_pkg::MO_IU:  begin ma = h1;   mb = tmrk4_pkg::C_IU; sh_in = tmrk4_pkg::SH_IU; end
         tmrk4_pkg::MO_II:  begin ma = xin;  mb = tmrk4_pkg::C_II; sh_in = tmrk4_pkg::SH_II; end
         tmrk4_pkg::MO_IW:  begin ma = h0;   mb = tmrk4_pkg::C_IW; sh_in = tmrk4_pkg::SH_IW; end
         tmrk4_pkg::MO_WI:  begin ma = h0;   mb = tmrk4_pkg::C_WI; sh_in = tmrk4_pkg::SH_WI; end
         tmrk4_pkg::MO_WW:  begin ma = xin;  mb = tmrk4_pkg::C_WW; sh_in = tmrk4_pkg::SH_WW; end
         tmrk4_pkg::MO_WSQ: begin ma = t_ff; mb = xin;             sh_in = SH_F; end
         tmrk4_pkg::MO_QR:  begin ma = h0;   mb = tmrk4_pkg::C_Q;  sh_in = tmrk4_pkg::SH_Q; end
         tmrk4_pkg::MO_QR2: begin ma = t_ff; mb = h0;              sh_in = SH_F; end
         tmrk4_pkg::MO_QL:  begin ma = h1;   mb = tmrk4_pkg::C_Q;  sh_in = tmrk4_pkg::SH_Q; end
         tmrk4_pkg::MO_QL2: begin ma = t_ff; mb = h1;              sh_in = SH_F; end
         tmrk4_pkg::MO_HS:  begin ma = dsat; end
         tmrk4_pkg::MO_HB:  begin ma = (kind == tmrk4_pkg::KIND_ANGLE) ? h0 : dsat; end
         tmrk4_pkg::MO_DIV: begin ma = kabs; mb = tmrk4_pkg::C_DIV6; end
         default: begin ma = dsat; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      v_in = v_ff;
      stage_in = stage_ff;
      op_in = op_ff;
      prod_in = prod_ff;
      dsum_in = dsum_ff;
      t_in = t_ff;
      xs_in = xs_ff;
      ksum_in = ksum_ff;
      nx_in = nx_ff;
      icr_in = icr_ff; icl_in = icl_ff; wr_in = wr_ff; wl_in = wl_ff;
      q_in = q_ff; th_in = th_ff;
      cnt_in = cnt_ff;
      vr_in = vr_ff; vl_in = vl_ff; hstep_in = hstep_ff; lim_in = lim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      done = 1'b0;
      emit = 1'b0;

      if (cfg_wr) begin
         case (csr_idx)
            tmrk4_pkg::REG_VOLT_RIGHT: vr_in = csr_pwdata[30:0];
            tmrk4_pkg::REG_VOLT_LEFT:  vl_in = csr_pwdata[30:0];
            tmrk4_pkg::REG_STEP_SIZE:  hstep_in = csr_pwdata[23:0];
            default:                   lim_in = csr_pwdata[15:0];
         endcase
      end

      case (state_ff)
         tmrk4_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tdata[0]) begin
                  icr_in = '0; icl_in = '0; wr_in = '0; wl_in = '0;
                  q_in = '0; th_in = '0; cnt_in = '0;
                  emit = 1'b1;
               end else if (cnt_ff < lim_ff) begin
                  state_in = tmrk4_pkg::ST_MUL;
                  v_in = 3'd0; stage_in = 2'd0; op_in = 3'd0; ksum_in = '0;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         tmrk4_pkg::ST_MUL: begin
            prod_in = 64'(ma) * 64'(mb);
            state_in = tmrk4_pkg::ST_WB;
         end
         tmrk4_pkg::ST_WB: begin
            state_in = tmrk4_pkg::ST_MUL;
            op_in = op_ff + 3'd1;
            case (mo)
               tmrk4_pkg::MO_IU, tmrk4_pkg::MO_WI, tmrk4_pkg::MO_QR2:
                  dsum_in = 34'(r);
               tmrk4_pkg::MO_II, tmrk4_pkg::MO_IW, tmrk4_pkg::MO_WSQ, tmrk4_pkg::MO_QL2:
                  dsum_in = dsum_ff - 34'(r);
               tmrk4_pkg::MO_WW, tmrk4_pkg::MO_QR, tmrk4_pkg::MO_QL:
                  t_in = r;
               tmrk4_pkg::MO_HS: begin
                  ksum_in = ksum_ff + (((stage_ff == 2'd1) || (stage_ff == 2'd2)) ?
                                       (k <<< 1) : k);
                  xs_in = tmrk4_pkg::sat32(64'(x0) +
                                           64'((stage_ff < 2'd2) ? khalf : k));
                  if (stage_ff == 2'd3) begin
                     op_in = 3'd4;
                  end else begin
                     op_in = 3'd0;
                     stage_in = stage_ff + 2'd1;
                  end
               end
               tmrk4_pkg::MO_DIV: begin
                  nx_in[v_ff] = tmrk4_pkg::sat32(64'(x0) + 64'(qv));
                  done = 1'b1;
               end
               default: begin
                  nx_in[v_ff] = tmrk4_pkg::sat32(64'(x0) + 64'(r));
                  done = 1'b1;
               end
            endcase
            if (done) begin
               op_in = 3'd0;
               stage_in = 2'd0;
               ksum_in = '0;
               if (v_ff == 3'd5) begin
                  state_in = tmrk4_pkg::ST_IDLE;
                  icr_in = nx_in[0]; icl_in = nx_in[1]; wr_in = nx_in[2];
                  wl_in = nx_in[3]; q_in = nx_in[4]; th_in = nx_in[5];
                  cnt_in = cnt_ff + 16'd1;
                  emit = 1'b1;
               end else begin
                  v_in = v_ff + 3'd1;
               end
            end
         end
         default: state_in = tmrk4_pkg::ST_IDLE;
      endcase

      fin = (cnt_in >= lim_ff);
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {7'd0, fin, cnt_in, th_in, q_in, wl_in, wr_in, icl_in, icr_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmrk4_pkg::ST_IDLE;
         v_ff <= '0;
         stage_ff <= '0;
         op_ff <= '0;
         icr_ff <= '0; icl_ff <= '0; wr_ff <= '0; wl_ff <= '0;
         q_ff <= '0; th_ff <= '0;
         cnt_ff <= '0;
         vr_ff <= VR_RST;
         vl_ff <= VL_RST;
         hstep_ff <= 24'd429497;
         lim_ff <= 16'd5000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v_ff <= v_in;
         stage_ff <= stage_in;
         op_ff <= op_in;
         icr_ff <= icr_in; icl_ff <= icl_in; wr_ff <= wr_in; wl_ff <= wl_in;
         q_ff <= q_in; th_ff <= th_in;
         cnt_ff <= cnt_in;
         vr_ff <= vr_in;
         vl_ff <= vl_in;
         hstep_ff <= hstep_in;
         lim_ff <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff <= sh_in;
      dsum_ff <= dsum_in;
      t_ff <= t_in;
      xs_ff <= xs_in;
      ksum_ff <= ksum_in;
      nx_ff <= nx_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == tmrk4_pkg::ST_IDLE))
      else $error("ready raised while a step is in progress");
   a_restart_resp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tdata[0]) |=> (rsp_valid_ff && (rsp_data_ff[207:192] == 16'd0)))
      else $error("restart item did not report a cleared count");
   a_var_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tmrk4_pkg::ST_IDLE) |-> (v_ff <= 3'd5))
      else $error("variable index out of range");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tmrk4_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during a step");
`endif

endmodule

// File: dv/twin_motor_roll_rk4_step_tb.sv
// Self-checking testbench for the two-motor roll-axis RK4 stepper, with its own fixed-point predictor.
module twin_motor_roll_rk4_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int ITEM_TARGET = 1850;

   localparam int SHIFT_IU = 19;
   localparam int SHIFT_II = 22;
   localparam int SHIFT_IW = 27;
   localparam int SHIFT_WI = 22;
   localparam int SHIFT_WW = 39;
   localparam int SHIFT_Q  = 45;
   localparam longint K_IU = ((longint'(100000) << SHIFT_IU) + 18) / 37;
   localparam longint K_II = ((longint'(12000) << SHIFT_II) + 18) / 37;
   localparam longint K_IW = ((longint'(330) << SHIFT_IW) + 18) / 37;
   localparam longint K_WI = ((longint'(33000) << SHIFT_WI) + 40) / 81;
   localparam longint K_WW = ((longint'(1) << SHIFT_WW) + 135) / 270;
   localparam longint K_Q  = ((longint'(21) << SHIFT_Q) + 200000) / 400000;

   typedef struct {
      logic [31:0] current_right;
      logic [31:0] current_left;
      logic [31:0] speed_right;
      logic [31:0] speed_left;
      logic [31:0] roll_rate;
      logic [31:0] roll_angle;
      logic [15:0] elapsed_steps;
      logic        finished;
   } drone_state_type;

   class roll_model_scoreboard;
      longint volt_right, volt_left, step_len, limit;
      longint i_r, i_l, w_r, w_l, rate, angle;
      int unsigned steps;
      drone_state_type expected_states[$];
      int errors;

      function new();
         volt_right = longint'(15) << (FRAC - 1);
         volt_left  = ((longint'(74) << FRAC) + 5) / 10;
         step_len   = 429497;
         limit      = 5000;
         clear();
         errors = 0;
      endfunction

      function void clear();
         i_r = 0; i_l = 0; w_r = 0; w_l = 0; rate = 0; angle = 0; steps = 0;
      endfunction

      function void configure(tmrk4_pkg::reg_type idx, logic [31:0] value);
         case (idx)
            tmrk4_pkg::REG_VOLT_RIGHT: volt_right = longint'(value & 32'h7FFFFFFF);
            tmrk4_pkg::REG_VOLT_LEFT:  volt_left  = longint'(value & 32'h7FFFFFFF);
            tmrk4_pkg::REG_STEP_SIZE:  step_len   = longint'(value & 32'h00FFFFFF);
            default:                   limit      = longint'(value & 32'h0000FFFF);
         endcase
      endfunction

      function longint clamp(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint scaled(longint a, longint b, int sh);
         return clamp((a * b) / (longint'(1) << sh));
      endfunction

      function longint slope(tmrk4_pkg::kind_type kind, longint x, longint h0, longint h1);
         case (kind)
            tmrk4_pkg::KIND_CURRENT:
               return clamp(scaled(h1, K_IU, SHIFT_IU) - scaled(x, K_II, SHIFT_II)
                            - scaled(h0, K_IW, SHIFT_IW));
            tmrk4_pkg::KIND_SPEED:
               return clamp(scaled(h0, K_WI, SHIFT_WI)
                            - scaled(scaled(x, K_WW, SHIFT_WW), x, FRAC));
            tmrk4_pkg::KIND_RATE:
               return clamp(scaled(scaled(h0, K_Q, SHIFT_Q), h0, FRAC)
                            - scaled(scaled(h1, K_Q, SHIFT_Q), h1, FRAC));
            default: return h0;
         endcase
      endfunction

      function longint times_step(longint d);
         return (d * step_len) / (longint'(1) << 32);
      endfunction

      function longint advance(tmrk4_pkg::kind_type kind, longint x, longint h0,
                               longint h1);
         longint k1, k2, k3, k4;
         k1 = times_step(slope(kind, x, h0, h1));
         k2 = times_step(slope(kind, clamp(x + k1 / 2), h0, h1));
         k3 = times_step(slope(kind, clamp(x + k2 / 2), h0, h1));
         k4 = times_step(slope(kind, clamp(x + k3), h0, h1));
         return clamp(x + (k1 + 2 * k2 + 2 * k3 + k4) / 6);
      endfunction

      function void note_item(logic restart);
         longint ir, il, wr, wl, q, th;
         drone_state_type s;
         if (restart) begin
            clear();
         end else if (longint'(steps) < limit) begin
            ir = i_r; il = i_l; wr = w_r; wl = w_l; q = rate; th = angle;
            i_r   = advance(tmrk4_pkg::KIND_CURRENT, ir, wr, volt_right);
            i_l   = advance(tmrk4_pkg::KIND_CURRENT, il, wl, volt_left);
            w_r   = advance(tmrk4_pkg::KIND_SPEED, wr, ir, 0);
            w_l   = advance(tmrk4_pkg::KIND_SPEED, wl, il, 0);
            rate  = advance(tmrk4_pkg::KIND_RATE, q, wr, wl);
            angle = advance(tmrk4_pkg::KIND_ANGLE, th, q, 0);
            steps = (steps + 1) & 16'hFFFF;
         end
         s.current_right = i_r[31:0];
         s.current_left  = i_l[31:0];
         s.speed_right   = w_r[31:0];
         s.speed_left    = w_l[31:0];
         s.roll_rate     = rate[31:0];
         s.roll_angle    = angle[31:0];
         s.elapsed_steps = steps[15:0];
         s.finished      = longint'(steps) >= limit;
         expected_states.push_back(s);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(logic [215:0] d);
         drone_state_type e;
         if (expected_states.size() == 0) begin
            report_mismatch("unexpected item", d[63:0], 64'd0);
            return;
         end
         e = expected_states.pop_front();
         if (d[31:0] !== e.current_right)
            report_mismatch("current_right", 64'(d[31:0]), 64'(e.current_right));
         if (d[63:32] !== e.current_left)
            report_mismatch("current_left", 64'(d[63:32]), 64'(e.current_left));
         if (d[95:64] !== e.speed_right)
            report_mismatch("speed_right", 64'(d[95:64]), 64'(e.speed_right));
         if (d[127:96] !== e.speed_left)
            report_mismatch("speed_left", 64'(d[127:96]), 64'(e.speed_left));
         if (d[159:128] !== e.roll_rate)
            report_mismatch("roll_rate", 64'(d[159:128]), 64'(e.roll_rate));
         if (d[191:160] !== e.roll_angle)
            report_mismatch("roll_angle", 64'(d[191:160]), 64'(e.roll_angle));
         if (d[207:192] !== e.elapsed_steps)
            report_mismatch("elapsed_steps", 64'(d[207:192]), 64'(e.elapsed_steps));
         if (d[208] !== e.finished)
            report_mismatch("finished", 64'(d[208]), 64'(e.finished));
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // [0] restart
   logic         rsp_tvalid;
   logic         rsp_tready = 1;
   // [31:0] current_right, [63:32] current_left, [95:64] speed_right,
   // [127:96] speed_left, [159:128] roll_rate, [191:160] roll_angle,
   // [207:192] elapsed_steps, [208] finished
   logic [215:0] rsp_tdata;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   roll_model_scoreboard board = new();
   longint cycles = 0;
   int stall_left = 0;
   bit steady = 0;
   int sent = 0;

   twin_motor_roll_rk4_step dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("twin_motor_roll_rk4_step_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_item(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata);
            stall_left = steady ? 0 : $urandom_range(0, 5);
            rsp_tready <= (stall_left == 0);
         end else if (!rsp_tready) begin
            if (stall_left > 0) stall_left--;
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   task send_item(logic restart);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'b0, restart};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.expected_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(tmrk4_pkg::reg_type idx, logic [31:0] value);
      drain();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 4'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.configure(idx, value);
   endtask

   function logic [31:0] pick_voltage();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFFFFFF;
         2: return $urandom();
         default: return $urandom_range(0, 24 << 16);
      endcase
   endfunction

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(1);
      repeat (3) send_item(0);
      write_reg(tmrk4_pkg::REG_STEP_LIMIT, 2);
      repeat (3) send_item(0);
      send_item(1);
      write_reg(tmrk4_pkg::REG_STEP_LIMIT, 0);
      send_item(0);
      send_item(1);
      write_reg(tmrk4_pkg::REG_STEP_LIMIT, 32'hFFFFFFFF);
      write_reg(tmrk4_pkg::REG_VOLT_RIGHT, 32'hFFFFFFFF);
      write_reg(tmrk4_pkg::REG_VOLT_LEFT, 32'h7FFFFFFF);
      write_reg(tmrk4_pkg::REG_STEP_SIZE, 32'hFFFFFFFF);
      repeat (8) send_item(0);
      write_reg(tmrk4_pkg::REG_STEP_SIZE, 0);
      repeat (2) send_item(0);
      write_reg(tmrk4_pkg::REG_STEP_SIZE, 32'h00FFFFFF);
      write_reg(tmrk4_pkg::REG_VOLT_RIGHT, 0);
      write_reg(tmrk4_pkg::REG_VOLT_LEFT, 0);
      repeat (3) send_item(0);
      send_item(1);

      while (sent < ITEM_TARGET) begin
         write_reg(tmrk4_pkg::REG_VOLT_RIGHT, pick_voltage());
         write_reg(tmrk4_pkg::REG_VOLT_LEFT, pick_voltage());
         case ($urandom_range(0, 5))
            0: write_reg(tmrk4_pkg::REG_STEP_SIZE, 32'h00FFFFFF);
            1: write_reg(tmrk4_pkg::REG_STEP_SIZE, $urandom_range(0, 1));
            2: write_reg(tmrk4_pkg::REG_STEP_SIZE, $urandom());
            default: write_reg(tmrk4_pkg::REG_STEP_SIZE, $urandom_range(1, 2000000));
         endcase
         if ($urandom_range(0, 2) == 0)
            write_reg(tmrk4_pkg::REG_STEP_LIMIT, $urandom_range(0, 60));
         else
            write_reg(tmrk4_pkg::REG_STEP_LIMIT, $urandom_range(1000, 65535));
         steady = ($urandom_range(0, 3) == 0);
         n = $urandom_range(20, 120);
         if ($urandom_range(0, 1) == 0) send_item(1);
         repeat (n) send_item($urandom_range(0, 19) == 0);
      end

      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.expected_states.size() == 0) begin
         $display("twin_motor_roll_rk4_step_tb: done, clean");
      end else begin
         $display("twin_motor_roll_rk4_step_tb: done, errors");
      end
      $finish;
   end
endmodule

// File: files.f
hw/rtl/tmrk4_pkg.sv
hw/rtl/twin_motor_roll_rk4_step.sv
dv/twin_motor_roll_rk4_step_tb.sv
